>>> hw/rtl/mds_pkg.sv
// shared types and constants for the match/delete stack
// no dependencies; used by mds_cell, mds_ctrl and match_delete_stack_top
package mds_pkg;

    localparam int DEPTH      = 16;
    localparam int ITEM_W     = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // result field widths
    localparam int VALUE_W    = 32;
    localparam int COUNT_W    = 5;
    localparam int STATUS_W   = 2;
    localparam int ACTION_W   = 2;

    // stream widths
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_FIELD_W = VALUE_W + COUNT_W + COUNT_W + 1 + STATUS_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_COUNT  = 2'd2,
        ACT_DELETE = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_POP_EMPTY = 2'd2
    } status_t;

    // what every cell does this cycle
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_PUSH = 2'd1,
        CELL_POP  = 2'd2,
        CELL_WALK = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     keep;   // walk: tail re-takes the head item
    } cell_cmd_t;

endpackage

>>> hw/rtl/mds_cell.sv
// one storage cell of the stack chain: an item word and an occupied flag
// depends on mds_pkg for widths and the cell command type
module mds_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  mds_pkg::cell_cmd_t        cmd,
    input  logic [mds_pkg::ITEM_W-1:0] head_data,  // item leaving cell 0
    input  logic [mds_pkg::ITEM_W-1:0] down_data,  // neighbor nearer the head
    input  logic                      down_occ,
    input  logic [mds_pkg::ITEM_W-1:0] up_data,    // neighbor nearer the bottom
    input  logic                      up_occ,
    output logic [mds_pkg::ITEM_W-1:0] data,
    output logic                      occ
);

    logic [mds_pkg::ITEM_W-1:0] data_reg, data_next;
    logic                       occ_reg, occ_next;
    logic                       is_tail;

    assign is_tail = occ_reg && !up_occ;

    // next contents from the broadcast command
    always_comb begin
        data_next = data_reg;
        occ_next  = occ_reg;
        case (cmd.op)
            mds_pkg::CELL_PUSH: begin
                data_next = down_data;
                occ_next  = down_occ;
            end
            mds_pkg::CELL_POP: begin
                data_next = up_data;
                occ_next  = up_occ;
            end
            mds_pkg::CELL_WALK: begin
                // shift toward the head; the tail slot takes back the head item
                data_next = is_tail ? head_data : up_data;
                occ_next  = up_occ || (is_tail && cmd.keep);
            end
            default: begin
                data_next = data_reg;
                occ_next  = occ_reg;
            end
        endcase
    end

    // item word, no reset needed
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    // occupied flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    assign data = data_reg;
    assign occ  = occ_reg;

endmodule

>>> hw/rtl/mds_ctrl.sv
// sequencer for the stack: takes requests, drives the cell chain, builds results
// depends on mds_pkg for the action, status and cell command types
module mds_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  mds_pkg::action_t               action,
    input  logic [mds_pkg::ITEM_W-1:0]     target,
    input  logic [mds_pkg::ITEM_W-1:0]     head_data,
    input  logic                           head_occ,
    output mds_pkg::cell_cmd_t             cmd,
    output logic [mds_pkg::CNT_W-1:0]      count,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mds_pkg::OUT_TDATA_W-1:0] m_tdata
);

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_WALK = 2'd1,
        S_FIN  = 2'd2
    } state_t;

    localparam logic [mds_pkg::CNT_W-1:0] FULL_CNT = mds_pkg::CNT_W'(mds_pkg::DEPTH);

    state_t                         state_reg;
    logic [mds_pkg::CNT_W-1:0]      count_reg;
    logic [mds_pkg::CNT_W-1:0]      steps_reg;
    logic [mds_pkg::CNT_W-1:0]      match_reg;
    logic [mds_pkg::ITEM_W-1:0]     target_reg;
    logic                           del_reg;
    mds_pkg::status_t               status_reg;
    logic                           m_tvalid_reg;
    logic [mds_pkg::OUT_TDATA_W-1:0] m_tdata_reg;

    logic accept;
    logic hit;
    logic out_free;
    logic [mds_pkg::VALUE_W-1:0] head_out;

    assign accept   = s_tvalid && (state_reg == S_IDLE);
    assign hit      = (head_data == target_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign head_out = head_occ ? mds_pkg::VALUE_W'(head_data) : '0;

    // cell command for this cycle
    always_comb begin
        cmd.op   = mds_pkg::CELL_HOLD;
        cmd.keep = 1'b1;
        case (state_reg)
            S_IDLE: begin
                if (accept && action == mds_pkg::ACT_PUSH && count_reg != FULL_CNT)
                    cmd.op = mds_pkg::CELL_PUSH;
                else if (accept && action == mds_pkg::ACT_POP && count_reg != '0)
                    cmd.op = mds_pkg::CELL_POP;
            end
            S_WALK: begin
                cmd.op   = mds_pkg::CELL_WALK;
                cmd.keep = !(del_reg && hit);
            end
            default: begin
                cmd.op   = mds_pkg::CELL_HOLD;
                cmd.keep = 1'b1;
            end
        endcase
    end

    // state, counters and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // result valid: set when a result is built, cleared once taken
            if (state_reg == S_FIN && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        target_reg <= target;
                        del_reg    <= (action == mds_pkg::ACT_DELETE);
                        match_reg  <= '0;
                        steps_reg  <= count_reg;
                        case (action)
                            mds_pkg::ACT_PUSH: begin
                                state_reg <= S_FIN;
                                if (count_reg == FULL_CNT) begin
                                    status_reg <= mds_pkg::ST_FULL;
                                end else begin
                                    status_reg <= mds_pkg::ST_OK;
                                    count_reg  <= count_reg + 1'b1;
                                end
                            end
                            mds_pkg::ACT_POP: begin
                                state_reg <= S_FIN;
                                if (count_reg == '0) begin
                                    status_reg <= mds_pkg::ST_POP_EMPTY;
                                end else begin
                                    status_reg <= mds_pkg::ST_OK;
                                    count_reg  <= count_reg - 1'b1;
                                end
                            end
                            default: begin
                                status_reg <= mds_pkg::ST_OK;
                                state_reg  <= (count_reg != '0) ? S_WALK : S_FIN;
                            end
                        endcase
                    end
                end
                S_WALK: begin
                    // one stored item passes the head per cycle
                    if (hit)
                        match_reg <= match_reg + 1'b1;
                    if (hit && del_reg)
                        count_reg <= count_reg - 1'b1;
                    steps_reg <= steps_reg - 1'b1;
                    if (steps_reg == mds_pkg::CNT_W'(1))
                        state_reg <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        m_tdata_reg  <= {{mds_pkg::OUT_PAD_W{1'b0}},
                                         status_reg,
                                         (count_reg == '0),
                                         mds_pkg::COUNT_W'(count_reg),
                                         mds_pkg::COUNT_W'(match_reg),
                                         head_out};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign count    = count_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> hw/rtl/match_delete_stack_top.sv
// top level of the match/delete stack: sequencer plus a chain of DEPTH cells
// depends on mds_pkg, mds_cell and mds_ctrl
//
// A last-in-first-out store of up to DEPTH items held in a row of cells, cell 0 being
// the head. Push and pop shift the whole row by one place. Count and delete walk the row:
// every cycle the head item is compared with the target and re-enters at the tail unless
// it is being deleted, so the order of the survivors is kept; the one comparator at the
// head of the chain does every compare. One request is worked at a time; a new request
// is taken while the previous result still waits on the output register. No clearing
// pass is needed after reset.
module match_delete_stack_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mds_pkg::IN_TDATA_W-1:0]  s_tdata,   // item_value[31:0]
    input  logic [mds_pkg::ACTION_W-1:0]    s_tuser,   // action[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // head_value[31:0], match_count[36:32], item_count[41:37], is_empty[42],
    // status[44:43], zero fill[47:45]
    output logic [mds_pkg::OUT_TDATA_W-1:0] m_tdata
);

    logic [mds_pkg::ITEM_W-1:0] cell_data [mds_pkg::DEPTH];
    logic [mds_pkg::DEPTH-1:0]  cell_occ;
    logic [mds_pkg::ITEM_W-1:0] item_in;
    mds_pkg::cell_cmd_t         cmd;
    logic [mds_pkg::CNT_W-1:0]  count;
    mds_pkg::action_t           action;

    assign item_in = s_tdata[mds_pkg::ITEM_W-1:0];
    assign action  = mds_pkg::action_t'(s_tuser);

    // sequencer
    mds_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .action    (action),
        .target    (item_in),
        .head_data (cell_data[0]),
        .head_occ  (cell_occ[0]),
        .cmd       (cmd),
        .count     (count),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // cell chain, cell 0 holds the head
    for (genvar i = 0; i < mds_pkg::DEPTH; i++) begin : g_cell
        logic [mds_pkg::ITEM_W-1:0] down_data;
        logic                       down_occ;
        logic [mds_pkg::ITEM_W-1:0] up_data;
        logic                       up_occ;

        if (i == 0) begin : g_first
            assign down_data = item_in;
            assign down_occ  = 1'b1;
        end else begin : g_inner_down
            assign down_data = cell_data[i-1];
            assign down_occ  = cell_occ[i-1];
        end

        if (i == mds_pkg::DEPTH - 1) begin : g_last
            assign up_data = '0;
            assign up_occ  = 1'b0;
        end else begin : g_inner_up
            assign up_data = cell_data[i+1];
            assign up_occ  = cell_occ[i+1];
        end

        mds_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmd       (cmd),
            .head_data (cell_data[0]),
            .down_data (down_data),
            .down_occ  (down_occ),
            .up_data   (up_data),
            .up_occ    (up_occ),
            .data      (cell_data[i]),
            .occ       (cell_occ[i])
        );
    end

`ifndef SYNTHESIS
    // occupied flags of the chain always agree with the item counter
    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(cell_occ) == 32'(count))
        else $error("cell occupancy does not match item count");

    // a push into a full store leaves the store as it was
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && action == mds_pkg::ACT_PUSH
         && count == mds_pkg::CNT_W'(mds_pkg::DEPTH))
        |=> ($stable(count) && $stable(cell_occ)))
        else $error("push into full store changed the store");

    // empty flag of a result agrees with its item count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[42] == (m_tdata[41:37] == 5'd0)))
        else $error("result empty flag disagrees with item count");
`endif

endmodule

>>> test/tb_top.sv
// self-checking testbench for match_delete_stack_top: stream driver, result monitor, scoreboard
// depends on mds_pkg and the match_delete_stack_top rtl; reads no files
`timescale 1ns / 1ps

module tb_top;
    import mds_pkg::*;

    localparam int HOLD_CYCLES = 300;    // long receiver hold-off, fills the block
    localparam int IDLE_LIMIT  = 4000;   // cycles without any request or result moving
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 100;

    // result field offsets inside m_tdata
    localparam int HEAD_LSB   = 0;
    localparam int MATCH_LSB  = HEAD_LSB + VALUE_W;
    localparam int COUNT_LSB  = MATCH_LSB + COUNT_W;
    localparam int EMPTY_LSB  = COUNT_LSB + COUNT_W;
    localparam int STATUS_LSB = EMPTY_LSB + 1;

    typedef struct packed {
        logic [VALUE_W-1:0]  head_value;
        logic [COUNT_W-1:0]  match_count;
        logic [COUNT_W-1:0]  item_count;
        logic                is_empty;
        logic [STATUS_W-1:0] status;
    } stack_result_t;

    typedef enum int {
        MIX_FILL,
        MIX_BALANCED,
        MIX_DRAIN
    } action_mix_t;

    // mirror of the stack contents plus the results still owed by the block
    class stack_scoreboard;
        logic [ITEM_W-1:0] stack_q[$];   // index 0 oldest, last entry is the head
        stack_result_t     owed_q[$];
        int                errors;

        function int pending();
            return owed_q.size();
        endfunction

        function void note_request(action_t act, logic [ITEM_W-1:0] val);
            stack_result_t     r;
            logic [ITEM_W-1:0] kept_q[$];
            r = '0;
            r.status = ST_OK;
            case (act)
                ACT_PUSH: begin
                    if (stack_q.size() >= DEPTH)
                        r.status = ST_FULL;
                    else
                        stack_q.push_back(val);
                end
                ACT_POP: begin
                    if (stack_q.size() == 0)
                        r.status = ST_POP_EMPTY;
                    else
                        void'(stack_q.pop_back());
                end
                ACT_COUNT: begin
                    foreach (stack_q[i])
                        if (stack_q[i] == val)
                            r.match_count++;
                end
                default: begin
                    // delete all matches, survivors keep their order
                    foreach (stack_q[i]) begin
                        if (stack_q[i] == val)
                            r.match_count++;
                        else
                            kept_q.push_back(stack_q[i]);
                    end
                    stack_q = kept_q;
                end
            endcase
            r.item_count = COUNT_W'(stack_q.size());
            r.is_empty   = (stack_q.size() == 0);
            r.head_value = (stack_q.size() > 0) ? stack_q[stack_q.size()-1] : '0;
            owed_q.push_back(r);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] d);
            stack_result_t want;
            stack_result_t got;
            got.head_value  = d[HEAD_LSB +: VALUE_W];
            got.match_count = d[MATCH_LSB +: COUNT_W];
            got.item_count  = d[COUNT_LSB +: COUNT_W];
            got.is_empty    = d[EMPTY_LSB];
            got.status      = d[STATUS_LSB +: STATUS_W];
            if (owed_q.size() == 0) begin
                $error("result with no request outstanding: tdata %h", d);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            if (got.head_value !== want.head_value) begin
                $error("head_value: expected %h, got %h", want.head_value, got.head_value);
                errors++;
            end
            if (got.match_count !== want.match_count) begin
                $error("match_count: expected %0d, got %0d", want.match_count, got.match_count);
                errors++;
            end
            if (got.item_count !== want.item_count) begin
                $error("item_count: expected %0d, got %0d", want.item_count, got.item_count);
                errors++;
            end
            if (got.is_empty !== want.is_empty) begin
                $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [ACTION_W-1:0]    s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    bit                     quiet_phase  = 1'b0;   // both sides run without gaps
    bit                     hold_off_req = 1'b0;   // receiver stalls for a long stretch
    logic [ITEM_W-1:0]      value_pool[4];
    int                     idle_cycles  = 0;

    stack_scoreboard sb = new();

    match_delete_stack_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // monitor both channels on every edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_request(action_t'(s_tuser), s_tdata[ITEM_W-1:0]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    // watchdog on stalled traffic
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result receiver with random stalls and one long hold-off
    initial begin
        int stall;
        forever begin
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end
            stall = quiet_phase ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // offer one request, return once it is taken
    task automatic send_request(action_t act, logic [ITEM_W-1:0] val);
        int gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= act;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // stop offering and wait for every owed result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // mostly values from a small pool so matches and duplicates are common
    function automatic logic [ITEM_W-1:0] pick_value();
        if ($urandom_range(0, 3) != 0)
            return value_pool[$urandom_range(0, 3)];
        return $urandom();
    endfunction

    function automatic action_t pick_action(action_mix_t mix);
        int roll;
        int push_pct;
        int pop_pct;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:     begin push_pct = 70; pop_pct = 5;  end
            MIX_BALANCED: begin push_pct = 40; pop_pct = 25; end
            default:      begin push_pct = 20; pop_pct = 45; end
        endcase
        if (roll < push_pct)
            return ACT_PUSH;
        if (roll < push_pct + pop_pct)
            return ACT_POP;
        if (roll < push_pct + pop_pct + (100 - push_pct - pop_pct) / 2)
            return ACT_COUNT;
        return ACT_DELETE;
    endfunction

    // main sequence
    initial begin
        action_mix_t mix;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty store corner cases
        send_request(ACT_POP,    32'h0000_0000);
        send_request(ACT_COUNT,  32'h0000_0000);
        send_request(ACT_DELETE, 32'hFFFF_FFFF);

        // fill to the top with a mix of extremes and repeats
        send_request(ACT_PUSH, 32'h0000_0000);
        send_request(ACT_PUSH, 32'hFFFF_FFFF);
        send_request(ACT_PUSH, 32'hA5A5_A5A5);
        send_request(ACT_PUSH, 32'h5A5A_5A5A);
        for (int i = 0; i < DEPTH - 4; i++)
            case (i % 4)
                0: send_request(ACT_PUSH, 32'hFFFF_FFFF);
                1: send_request(ACT_PUSH, 32'h8000_0001);
                2: send_request(ACT_PUSH, 32'h0000_0000);
                default: send_request(ACT_PUSH, 32'h1234_5678 + i);
            endcase

        // push when full is dropped
        send_request(ACT_PUSH,   32'h7FFF_FFFF);
        send_request(ACT_COUNT,  32'hFFFF_FFFF);
        send_request(ACT_COUNT,  32'hDEAD_BEEF);
        send_request(ACT_DELETE, 32'hFFFF_FFFF);
        send_request(ACT_DELETE, 32'h0000_0000);
        send_request(ACT_POP,    32'h0000_0000);
        drain_results();

        // random phases with changing action mix and idling
        for (int phase = 0; phase < PHASES; phase++) begin
            foreach (value_pool[k])
                value_pool[k] = $urandom();
            quiet_phase = (phase == 3) || (phase == 6);
            mix = action_mix_t'(phase % 3);
            if (phase == 2)
                hold_off_req = 1'b1;
            if (phase == 5)
                drain_results();
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_request(pick_action(mix), pick_value());
        end
        quiet_phase = 1'b0;

        drain_results();
        repeat (DEPTH + 8) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
